>>> src/llgl_pkg.sv
// ----------------------------------------------------------------------------
// llgl_pkg: shared types and constants of the grid locator encoder
// Coordinate widths, cell sizes per character pair, queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package llgl_pkg;

  // coordinate and index widths
  localparam int unsigned COORD_W  = 20;
  localparam int unsigned IDX_W    = 20;
  localparam int unsigned SUM_W    = IDX_W + 1;
  localparam int unsigned PAIRS_W  = 3;
  localparam int unsigned DIGIT_W  = 5;
  localparam int unsigned CHAR_W   = 7;

  // offset to a non-negative cell index and top of the span
  localparam logic [SUM_W-1:0] OFFSET_UNITS = SUM_W'(518400);
  localparam logic [SUM_W-1:0] SPAN_MAX     = SUM_W'(1036799);

  // pair count limits
  localparam logic [PAIRS_W-1:0] MIN_PAIRS     = PAIRS_W'(1);
  localparam logic [PAIRS_W-1:0] MAX_PAIRS     = PAIRS_W'(5);
  localparam logic [PAIRS_W-1:0] DEFAULT_PAIRS = PAIRS_W'(3);
  localparam int unsigned        NUM_PAIRS     = 5;

  // largest radix of any digit position
  localparam int unsigned RADIX_MAX = 24;

  // cell size in input units for each pair, coarse to fine
  localparam logic [SUM_W-1:0] CELL_UNITS [NUM_PAIRS] = '{
    SUM_W'(57600), SUM_W'(5760), SUM_W'(240), SUM_W'(24), SUM_W'(1)
  };

  // character bases
  localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT  = 7'h30;

  // default depth of the queue between front and back
  localparam int unsigned DEF_QUEUE_DEPTH = 2;

  // one classified coordinate waiting for digit extraction
  typedef struct packed {
    logic [PAIRS_W-1:0] pairs;
    logic [IDX_W-1:0]   lat_idx;
    logic [IDX_W-1:0]   lon_idx;
  } llgl_item_t;

endpackage

`default_nettype wire

>>> src/llgl_front.sv
// ----------------------------------------------------------------------------
// llgl_front: input stage of the grid locator encoder
// Offsets and clamps both coordinates and fixes the pair count per item.
// ----------------------------------------------------------------------------
`default_nettype none

module llgl_front import llgl_pkg::*; (
  input  wire logic [COORD_W-1:0] lon_i,
  input  wire logic [COORD_W-1:0] lat_i,
  input  wire logic [PAIRS_W-1:0] pairs_i,
  output llgl_item_t              item_o
);

  // offset a two's complement coordinate and clamp it to the span
  function automatic logic [IDX_W-1:0] to_index(input logic [COORD_W-1:0] raw);
    logic [SUM_W-1:0] sum;
    sum = {raw[COORD_W-1], raw} + OFFSET_UNITS;
    if (sum[SUM_W-1]) begin
      to_index = '0;
    end else if (sum > SPAN_MAX) begin
      to_index = SPAN_MAX[IDX_W-1:0];
    end else begin
      to_index = sum[IDX_W-1:0];
    end
  endfunction

  // classify: clamp coordinates, replace a bad pair count by the default
  always_comb begin
    item_o.lon_idx = to_index(lon_i);
    item_o.lat_idx = to_index(lat_i);
    if (pairs_i < MIN_PAIRS || pairs_i > MAX_PAIRS) begin
      item_o.pairs = DEFAULT_PAIRS;
    end else begin
      item_o.pairs = pairs_i;
    end
  end

endmodule

`default_nettype wire

>>> src/llgl_queue.sv
// ----------------------------------------------------------------------------
// llgl_queue: short queue between front and back
// Holds classified items so that each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module llgl_queue import llgl_pkg::*; #(
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire llgl_item_t push_item_i,
  output logic       full_o,
  input  wire logic pop_i,
  output llgl_item_t head_o,
  output logic       empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  llgl_item_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
    if (ptr == PTR_W'(DEPTH - 1)) begin
      next_ptr = '0;
    end else begin
      next_ptr = ptr + PTR_W'(1);
    end
  endfunction

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rptr_q];

  // advance pointers and occupancy
  always_comb begin
    wptr_d = do_push ? next_ptr(wptr_q) : wptr_q;
    rptr_d = do_pop ? next_ptr(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // store entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

>>> src/llgl_back.sv
// ----------------------------------------------------------------------------
// llgl_back: digit extraction sequencer of the grid locator encoder
// Extracts one digit pair per cycle from the queue head item while the output does not stall, and drives the output.
// ----------------------------------------------------------------------------
`default_nettype none

module llgl_back import llgl_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire llgl_item_t         head_i,
  input  wire logic               head_valid_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [CHAR_W-1:0]       lon_char_o,
  output logic [CHAR_W-1:0]       lat_char_o,
  output logic                    last_o
);

  logic               busy_q, busy_d;
  logic [PAIRS_W-1:0] idx_q, idx_d;
  logic [PAIRS_W-1:0] pairs_q, pairs_d;
  logic [IDX_W-1:0]   lon_rem_q, lon_rem_d;
  logic [IDX_W-1:0]   lat_rem_q, lat_rem_d;
  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  lon_char_q, lon_char_d;
  logic [CHAR_W-1:0]  lat_char_q, lat_char_d;
  logic               last_q, last_d;

  logic               advance, step, is_last;
  logic [PAIRS_W-1:0] cur_idx, cur_pairs;
  logic [IDX_W-1:0]   cur_lon, cur_lat;
  logic [DIGIT_W-1:0] lon_digit, lat_digit;
  logic [SUM_W-1:0]   lon_sub, lat_sub;
  logic [SUM_W-1:0]   mult;

  // select operands: queue head on a new item, held remainders otherwise
  always_comb begin
    cur_idx   = busy_q ? idx_q     : '0;
    cur_pairs = busy_q ? pairs_q   : head_i.pairs;
    cur_lon   = busy_q ? lon_rem_q : head_i.lon_idx;
    cur_lat   = busy_q ? lat_rem_q : head_i.lat_idx;
  end

  // digit: largest multiple of the cell size not above the remainder
  always_comb begin
    lon_digit = '0;
    lat_digit = '0;
    lon_sub   = '0;
    lat_sub   = '0;
    mult      = '0;
    for (int k = 1; k < RADIX_MAX; k++) begin
      mult = '0;
      for (int p = 0; p < NUM_PAIRS; p++) begin
        if (cur_idx == PAIRS_W'(p)) begin
          mult = SUM_W'(CELL_UNITS[p] * k);
        end
      end
      if ({1'b0, cur_lon} >= mult) begin
        lon_digit = DIGIT_W'(k);
        lon_sub   = mult;
      end
      if ({1'b0, cur_lat} >= mult) begin
        lat_digit = DIGIT_W'(k);
        lat_sub   = mult;
      end
    end
  end

  assign advance = !out_valid_q || out_ready_i;
  assign step    = advance && (busy_q || head_valid_i);
  assign is_last = ((cur_idx + PAIRS_W'(1)) == cur_pairs);
  assign pop_o   = step && !busy_q;

  // sequence pairs and load the output register
  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    pairs_d     = pairs_q;
    lon_rem_d   = lon_rem_q;
    lat_rem_d   = lat_rem_q;
    out_valid_d = out_valid_q;
    lon_char_d  = lon_char_q;
    lat_char_d  = lat_char_q;
    last_d      = last_q;
    if (step) begin
      busy_d      = !is_last;
      idx_d       = cur_idx + PAIRS_W'(1);
      pairs_d     = cur_pairs;
      lon_rem_d   = IDX_W'({1'b0, cur_lon} - lon_sub);
      lat_rem_d   = IDX_W'({1'b0, cur_lat} - lat_sub);
      out_valid_d = 1'b1;
      if (cur_idx[0]) begin
        lon_char_d = CHAR_DIGIT + CHAR_W'(lon_digit);
        lat_char_d = CHAR_DIGIT + CHAR_W'(lat_digit);
      end else begin
        lon_char_d = CHAR_LETTER + CHAR_W'(lon_digit);
        lat_char_d = CHAR_LETTER + CHAR_W'(lat_digit);
      end
      last_d = is_last;
    end else if (advance) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hold remainders and output payload
  always_ff @(posedge clk_i) begin
    pairs_q    <= pairs_d;
    lon_rem_q  <= lon_rem_d;
    lat_rem_q  <= lat_rem_d;
    lon_char_q <= lon_char_d;
    lat_char_q <= lat_char_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign lon_char_o  = lon_char_q;
  assign lat_char_o  = lat_char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

>>> src/latlon_to_grid_locator_core.sv
// ----------------------------------------------------------------------------
// latlon_to_grid_locator_core: Maidenhead locator encoder, up to 10 characters
// Turns a fixed point longitude/latitude into one character pair per beat.
// ----------------------------------------------------------------------------
//  channel  direction  transaction contents
//  s_axis   in         longitude [19:0], latitude [39:20], both signed
//  m_axis   out        lon_char [6:0], lat_char [13:7]; tlast on final pair
//  cfg      in         locator_pairs [2:0], written when cfg_we_i is high
//
//  An item gives locator_pairs output beats (1 to 5; other values give 3),
//  one per cycle, formed by the digit sequencer in the back part. The first
//  beat of an item passes the queue storage and then the output register.
//  The input takes a new item each cycle until the queue of QUEUE_DEPTH
//  items is full; output stalls hold the sequencer.
//  Reset clears the queue, the sequencer and sets locator_pairs to 3.
// ----------------------------------------------------------------------------
`default_nettype none

module latlon_to_grid_locator_core import llgl_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [PAIRS_W-1:0] cfg_wdata_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [39:0]        s_axis_tdata,  // longitude [19:0], latitude [39:20]
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [15:0]             m_axis_tdata,  // lon_char [6:0], lat_char [13:7], zero
  output logic                    m_axis_tlast
);

  logic [PAIRS_W-1:0] pairs_q;
  llgl_item_t         front_item;
  llgl_item_t         head_item;
  logic               q_full, q_empty, q_pop;
  logic [CHAR_W-1:0]  lon_char, lat_char;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pairs_q <= DEFAULT_PAIRS;
    end else if (cfg_we_i) begin
      pairs_q <= cfg_wdata_i;
    end
  end

  // classify incoming coordinates
  llgl_front u_front (
    .lon_i   (s_axis_tdata[COORD_W-1:0]),
    .lat_i   (s_axis_tdata[2*COORD_W-1:COORD_W]),
    .pairs_i (pairs_q),
    .item_o  (front_item)
  );

  // decouple front and back
  llgl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_item_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (head_item),
    .empty_o     (q_empty)
  );

  assign s_axis_tready = !q_full;

  // extract digits and drive the output
  llgl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_item),
    .head_valid_i (!q_empty),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .lon_char_o   (lon_char),
    .lat_char_o   (lat_char),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, lat_char, lon_char};

endmodule

`default_nettype wire
